// ----- hdl/icr_pkg.sv -----
// ----------------------------------------------------------------------------
// icr_pkg
// Shared constants, verdict codes and checksum helper for the ICMP receive
// classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package icr_pkg;

	localparam int unsigned MaxReplyIcmpLen = 1480;

	// ICMP message types
	localparam logic [7:0] IcmpEchoReply     = 8'd0;
	localparam logic [7:0] IcmpUnreach       = 8'd3;
	localparam logic [7:0] IcmpQuench        = 8'd4;
	localparam logic [7:0] IcmpRedirect      = 8'd5;
	localparam logic [7:0] IcmpEchoRequest   = 8'd8;
	localparam logic [7:0] IcmpTimeExceeded  = 8'd11;
	localparam logic [7:0] IcmpParamProblem  = 8'd12;

	// one past the highest known codes
	localparam logic [7:0] UnreachCodeLimit  = 8'd6;
	localparam logic [7:0] RedirectCodeLimit = 8'd4;

	// echo reply header words
	localparam logic [15:0] ReplyVerIhl   = 16'h4500;
	localparam logic [15:0] ReplyTtlProto = 16'hFA01;
	localparam logic [15:0] IpHdrBytes    = 16'd20;
	localparam logic [5:0]  MinHdrBytes   = 6'd20;
	localparam logic [15:0] SumAllOnes    = 16'hFFFF;

	typedef enum logic [3:0] {
		KIND_DROP       = 4'd0,
		KIND_SEND_ECHO  = 4'd1,
		KIND_OUR_ECHO   = 4'd2,
		KIND_FOREIGN    = 4'd3,
		KIND_UNREACH    = 4'd4,
		KIND_QUENCH     = 4'd5,
		KIND_REDIRECT   = 4'd6,
		KIND_TIME_EXC   = 4'd7,
		KIND_PARAM_PROB = 4'd8,
		KIND_OTHER      = 4'd9
	} kind_t;

	// one's-complement add of two 16-bit words with end-around carry
	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] w);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, w};
		return s[15:0] + {15'b0, s[16]};
	endfunction

endpackage

`default_nettype wire

// ----- hdl/icr_rx_if.sv -----
// ----------------------------------------------------------------------------
// icr_rx_if
// Byte request channel: one datagram byte and its end marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface icr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       last;

	modport source (output valid, output rx_byte, output last, input ready);
	modport sink   (input valid, input rx_byte, input last, output ready);
endinterface

`default_nettype wire

// ----- hdl/icr_verdict_if.sv -----
// ----------------------------------------------------------------------------
// icr_verdict_if
// Verdict channel: one classification request per received datagram.
// ----------------------------------------------------------------------------
`default_nettype none

interface icr_verdict_if;
	logic        valid;
	logic        ready;
	logic [3:0]  kind;
	logic [7:0]  msg_code;
	logic [15:0] reply_ip_checksum;
	logic [15:0] reply_icmp_checksum;
	logic [15:0] reply_ident;
	logic [10:0] reply_length;
	logic [31:0] peer_address;
	logic [31:0] gateway_address;
	logic [7:0]  returned_proto;
	logic [31:0] returned_source;
	logic [31:0] returned_dest;
	logic [2:0]  unreach_status;

	modport source (output valid, output kind, output msg_code, output reply_ip_checksum,
		output reply_icmp_checksum, output reply_ident, output reply_length,
		output peer_address, output gateway_address, output returned_proto,
		output returned_source, output returned_dest, output unreach_status, input ready);
	modport sink (input valid, input kind, input msg_code, input reply_ip_checksum,
		input reply_icmp_checksum, input reply_ident, input reply_length,
		input peer_address, input gateway_address, input returned_proto,
		input returned_source, input returned_dest, input unreach_status, output ready);
endinterface

`default_nettype wire

// ----- hdl/icmp_receive_classifier.sv -----
// ----------------------------------------------------------------------------
// icmp_receive_classifier
// Byte-serial ICMP receive path: checksum accumulation, header capture and a
// single verdict per datagram, with echo reply checksums and identification.
// Throughput: one byte per cycle, except that a last byte waits for room
// in the later stages; the per-byte checksum update in the first stage sets
// that rate. The stage 2, 3 and 4 registers lie between it and the verdict.
// Reset: arst_n clears own address, byte count, reply ident and all valids.
// ----------------------------------------------------------------------------
`default_nettype none

module icmp_receive_classifier #(
	parameter int unsigned MAX_REPLY_ICMP_LEN = icr_pkg::MaxReplyIcmpLen
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [31:0]          cfg_wdata,
	icr_rx_if.sink               rx,
	icr_verdict_if.source        verdict
);

	localparam logic [15:0] MaxLen = 16'(MAX_REPLY_ICMP_LEN);

	logic [31:0] own_address_q;

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4;
	logic out_free, s3_free, s2_free, s1_go, s1_free;

	// input stage
	logic [7:0] byte_s1;
	logic       last_s1;

	// packet state
	logic [15:0] bc_q, tot_q, rx_sum_q, reply_sum_q;
	logic [5:0]  hdr_q;
	logic [7:0]  odd_q, type_q, code_q, rproto_q;
	logic [31:0] src_q, dst_q, w4_q, rsrc_q, rdst_q;
	logic [15:0] id_q;

	// next packet state
	logic [15:0] bc_n, bc_inc, tot_n, rx_sum_n, reply_sum_n;
	logic [5:0]  hdr_n;
	logic [7:0]  odd_n, type_n, code_n, rproto_n;
	logic [31:0] src_n, dst_n, w4_n, rsrc_n, rdst_n;
	logic        first;
	logic        in_icmp;
	logic [15:0] off, len1, clamp1, off_inc;
	logic [7:0]  hi_b, lo_b;

	// snapshot at the last byte
	logic [15:0] bc_s2, tot_s2, rx_sum_s2, reply_sum_s2;
	logic [5:0]  hdr_s2;
	logic [7:0]  type_s2, code_s2, rproto_s2;
	logic [31:0] src_s2, dst_s2, w4_s2, rsrc_s2, rdst_s2;

	// classification stage
	icr_pkg::kind_t kind_c, kind_s3;
	logic        accept_c;
	logic [15:0] len3, clamp3, rlen_c;
	logic [18:0] part_c;
	logic [7:0]  code_s3, rproto_s3;
	logic [31:0] peer_s3, gw_s3, rsrc_s3, rdst_s3;
	logic [15:0] icmp_ck_s3, rlen_s3;
	logic [18:0] part_s3;
	logic [2:0]  unreach_s3;
	logic        send_s3;

	// verdict stage
	logic [18:0] ip_sum;
	logic [16:0] ip_f1;
	logic [15:0] ip_f2;
	icr_pkg::kind_t kind_s4;
	logic [7:0]  code_s4, rproto_s4;
	logic [15:0] ip_ck_s4, icmp_ck_s4, ident_s4;
	logic [10:0] rlen_s4;
	logic [31:0] peer_s4, gw_s4, rsrc_s4, rdst_s4;
	logic [2:0]  unreach_s4;

	// ------------------------------------------------------------------------
	// handshake: only last bytes travel past the first stage
	// ------------------------------------------------------------------------
	assign out_free = !v_s4 || verdict.ready;
	assign s3_free  = !v_s3 || out_free;
	assign s2_free  = !v_s2 || s3_free;
	assign s1_go    = v_s1 && (!last_s1 || s2_free);
	assign s1_free  = !v_s1 || s1_go;
	assign rx.ready = s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			v_s4          <= 1'b0;
			own_address_q <= '0;
			bc_q          <= '0;
			id_q          <= '0;
		end else begin
			if (cfg_we) begin
				own_address_q <= cfg_wdata;
			end
			if (s1_free) begin
				v_s1 <= rx.valid;
			end
			if (s2_free) begin
				v_s2 <= s1_go && last_s1;
			end
			if (s3_free) begin
				v_s3 <= v_s2;
			end
			if (out_free) begin
				v_s4 <= v_s3;
			end
			if (s1_go) begin
				bc_q <= bc_n;
			end
			// advance the ident for every echo reply sent
			if (out_free && v_s3 && send_s3) begin
				id_q <= id_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free) begin
			byte_s1 <= rx.rx_byte;
			last_s1 <= rx.last;
		end
	end

	// ------------------------------------------------------------------------
	// stage 1: per-byte capture and checksum accumulation
	// ------------------------------------------------------------------------
	always_comb begin
		first       = (bc_q == 16'd0);
		hdr_n       = first ? '0 : hdr_q;
		tot_n       = first ? '0 : tot_q;
		rx_sum_n    = first ? '0 : rx_sum_q;
		reply_sum_n = first ? '0 : reply_sum_q;
		odd_n       = first ? '0 : odd_q;
		type_n      = first ? '0 : type_q;
		code_n      = first ? '0 : code_q;
		src_n       = first ? '0 : src_q;
		dst_n       = first ? '0 : dst_q;
		w4_n        = first ? '0 : w4_q;
		rproto_n    = first ? '0 : rproto_q;
		rsrc_n      = first ? '0 : rsrc_q;
		rdst_n      = first ? '0 : rdst_q;
		hi_b        = '0;
		lo_b        = '0;

		priority if (bc_q == 16'd0) begin
			hdr_n = {byte_s1[3:0], 2'b00};
		end else if (bc_q == 16'd2) begin
			tot_n = {byte_s1, tot_n[7:0]};
		end else if (bc_q == 16'd3) begin
			tot_n = {tot_n[15:8], byte_s1};
		end else if (bc_q >= 16'd12 && bc_q <= 16'd15) begin
			src_n = {src_n[23:0], byte_s1};
		end else if (bc_q >= 16'd16 && bc_q <= 16'd19) begin
			dst_n = {dst_n[23:0], byte_s1};
		end else begin
		end

		in_icmp = (hdr_n >= icr_pkg::MinHdrBytes) && (bc_q >= {10'b0, hdr_n})
			&& (bc_q < tot_n);
		off     = bc_q - {10'b0, hdr_n};
		off_inc = off + 16'd1;
		len1    = tot_n - {10'b0, hdr_n};
		clamp1  = (len1 > MaxLen) ? MaxLen : len1;

		if (in_icmp) begin
			priority if (off == 16'd0) begin
				type_n = byte_s1;
			end else if (off == 16'd1) begin
				code_n = byte_s1;
			end else if (off >= 16'd4 && off <= 16'd7) begin
				w4_n = {w4_n[23:0], byte_s1};
			end else if (off >= 16'd17 && off <= 16'd27) begin
				// returned header bytes land in fixed slots
				unique case (off[4:0])
					5'd17:   rproto_n       = byte_s1;
					5'd20:   rsrc_n[31:24]  = byte_s1;
					5'd21:   rsrc_n[23:16]  = byte_s1;
					5'd22:   rsrc_n[15:8]   = byte_s1;
					5'd23:   rsrc_n[7:0]    = byte_s1;
					5'd24:   rdst_n[31:24]  = byte_s1;
					5'd25:   rdst_n[23:16]  = byte_s1;
					5'd26:   rdst_n[15:8]   = byte_s1;
					5'd27:   rdst_n[7:0]    = byte_s1;
					default: ;
				endcase
			end else begin
			end

			if (off[0]) begin
				rx_sum_n = icr_pkg::oc_add(rx_sum_n, {odd_n, byte_s1});
				if (off < clamp1) begin
					// reply carries type zero and a zero checksum field
					hi_b = (off == 16'd1 || off == 16'd3) ? 8'd0 : odd_n;
					lo_b = (off == 16'd3) ? 8'd0 : byte_s1;
					reply_sum_n = icr_pkg::oc_add(reply_sum_n, {hi_b, lo_b});
				end
			end else begin
				odd_n = byte_s1;
				if (off_inc == len1) begin
					rx_sum_n = icr_pkg::oc_add(rx_sum_n, {byte_s1, 8'd0});
				end
				if (off_inc == clamp1) begin
					hi_b = (off == 16'd0 || off == 16'd2) ? 8'd0 : byte_s1;
					reply_sum_n = icr_pkg::oc_add(reply_sum_n, {hi_b, 8'd0});
				end
			end
		end

		bc_inc = (bc_q == 16'hFFFF) ? bc_q : bc_q + 16'd1;
		bc_n   = last_s1 ? 16'd0 : bc_inc;
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			hdr_q       <= hdr_n;
			tot_q       <= tot_n;
			rx_sum_q    <= rx_sum_n;
			reply_sum_q <= reply_sum_n;
			odd_q       <= odd_n;
			type_q      <= type_n;
			code_q      <= code_n;
			src_q       <= src_n;
			dst_q       <= dst_n;
			w4_q        <= w4_n;
			rproto_q    <= rproto_n;
			rsrc_q      <= rsrc_n;
			rdst_q      <= rdst_n;
		end
		if (s2_free) begin
			bc_s2        <= bc_inc;
			hdr_s2       <= hdr_n;
			tot_s2       <= tot_n;
			rx_sum_s2    <= rx_sum_n;
			reply_sum_s2 <= reply_sum_n;
			type_s2      <= type_n;
			code_s2      <= code_n;
			src_s2       <= src_n;
			dst_s2       <= dst_n;
			w4_s2        <= w4_n;
			rproto_s2    <= rproto_n;
			rsrc_s2      <= rsrc_n;
			rdst_s2      <= rdst_n;
		end
	end

	// ------------------------------------------------------------------------
	// stage 3: classify and prepare reply fields
	// ------------------------------------------------------------------------
	always_comb begin
		len3   = (tot_s2 >= {10'b0, hdr_s2}) ? tot_s2 - {10'b0, hdr_s2} : 16'd0;
		clamp3 = (len3 > MaxLen) ? MaxLen : len3;
		rlen_c = icr_pkg::IpHdrBytes + clamp3;
		part_c = {3'b0, icr_pkg::ReplyVerIhl} + {3'b0, icr_pkg::ReplyTtlProto}
			+ {3'b0, dst_s2[31:16]} + {3'b0, dst_s2[15:0]}
			+ {3'b0, src_s2[31:16]} + {3'b0, src_s2[15:0]};

		accept_c = (hdr_s2 >= icr_pkg::MinHdrBytes) && (tot_s2 >= {10'b0, hdr_s2})
			&& (bc_s2 >= tot_s2) && (rx_sum_s2 == icr_pkg::SumAllOnes)
			&& (own_address_q != 32'd0) && (dst_s2 == own_address_q);

		kind_c = icr_pkg::KIND_DROP;
		if (accept_c) begin
			unique case (type_s2)
				icr_pkg::IcmpEchoReply:
					kind_c = (w4_s2[31:16] == own_address_q[31:16])
						? icr_pkg::KIND_OUR_ECHO : icr_pkg::KIND_FOREIGN;
				icr_pkg::IcmpUnreach:
					kind_c = (code_s2 < icr_pkg::UnreachCodeLimit)
						? icr_pkg::KIND_UNREACH : icr_pkg::KIND_OTHER;
				icr_pkg::IcmpQuench:
					kind_c = icr_pkg::KIND_QUENCH;
				icr_pkg::IcmpRedirect:
					kind_c = (code_s2 < icr_pkg::RedirectCodeLimit)
						? icr_pkg::KIND_REDIRECT : icr_pkg::KIND_OTHER;
				icr_pkg::IcmpEchoRequest:
					// never answer toward a broadcast
					kind_c = (src_s2 == 32'd0 || src_s2 == 32'hFFFF_FFFF
						|| own_address_q == 32'hFFFF_FFFF)
						? icr_pkg::KIND_DROP : icr_pkg::KIND_SEND_ECHO;
				icr_pkg::IcmpTimeExceeded:
					kind_c = icr_pkg::KIND_TIME_EXC;
				icr_pkg::IcmpParamProblem:
					kind_c = icr_pkg::KIND_PARAM_PROB;
				default:
					kind_c = icr_pkg::KIND_OTHER;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s3_free) begin
			kind_s3    <= kind_c;
			send_s3    <= (kind_c == icr_pkg::KIND_SEND_ECHO);
			code_s3    <= (kind_c != icr_pkg::KIND_DROP) ? code_s2 : 8'd0;
			peer_s3    <= (kind_c != icr_pkg::KIND_DROP) ? src_s2 : 32'd0;
			gw_s3      <= (kind_c == icr_pkg::KIND_REDIRECT) ? w4_s2 : 32'd0;
			icmp_ck_s3 <= (kind_c == icr_pkg::KIND_SEND_ECHO) ? ~reply_sum_s2 : 16'd0;
			rlen_s3    <= (kind_c == icr_pkg::KIND_SEND_ECHO) ? rlen_c : 16'd0;
			part_s3    <= part_c;
			if (kind_c >= icr_pkg::KIND_UNREACH && kind_c <= icr_pkg::KIND_PARAM_PROB) begin
				rproto_s3 <= rproto_s2;
				rsrc_s3   <= rsrc_s2;
				rdst_s3   <= rdst_s2;
			end else begin
				rproto_s3 <= '0;
				rsrc_s3   <= '0;
				rdst_s3   <= '0;
			end
			unreach_s3 <= (kind_c == icr_pkg::KIND_UNREACH) ? code_s2[2:0] + 3'd1 : 3'd0;
		end
	end

	// ------------------------------------------------------------------------
	// stage 4: reply IP header checksum and verdict register
	// ------------------------------------------------------------------------
	always_comb begin
		ip_sum = part_s3 + {3'b0, rlen_s3} + {3'b0, id_q};
		ip_f1  = {1'b0, ip_sum[15:0]} + {14'b0, ip_sum[18:16]};
		ip_f2  = ip_f1[15:0] + {15'b0, ip_f1[16]};
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			kind_s4    <= kind_s3;
			code_s4    <= code_s3;
			ip_ck_s4   <= send_s3 ? ~ip_f2 : 16'd0;
			icmp_ck_s4 <= icmp_ck_s3;
			ident_s4   <= send_s3 ? id_q : 16'd0;
			rlen_s4    <= rlen_s3[10:0];
			peer_s4    <= peer_s3;
			gw_s4      <= gw_s3;
			rproto_s4  <= rproto_s3;
			rsrc_s4    <= rsrc_s3;
			rdst_s4    <= rdst_s3;
			unreach_s4 <= unreach_s3;
		end
	end

	assign verdict.valid               = v_s4;
	assign verdict.kind                = kind_s4;
	assign verdict.msg_code            = code_s4;
	assign verdict.reply_ip_checksum   = ip_ck_s4;
	assign verdict.reply_icmp_checksum = icmp_ck_s4;
	assign verdict.reply_ident         = ident_s4;
	assign verdict.reply_length        = rlen_s4;
	assign verdict.peer_address        = peer_s4;
	assign verdict.gateway_address     = gw_s4;
	assign verdict.returned_proto      = rproto_s4;
	assign verdict.returned_source     = rsrc_s4;
	assign verdict.returned_dest       = rdst_s4;
	assign verdict.unreach_status      = unreach_s4;

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	a_drop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && kind_s4 == icr_pkg::KIND_DROP |-> peer_s4 == 32'd0 && code_s4 == 8'd0)
		else $error("drop verdict carries message fields");

	a_reply_only_on_send: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && kind_s4 != icr_pkg::KIND_SEND_ECHO |-> rlen_s4 == 11'd0 && ip_ck_s4 == 16'd0)
		else $error("reply fields set on a verdict that sends nothing");

	a_ident_step: assert property (@(posedge clk) disable iff (!arst_n)
		id_q != $past(id_q) |-> $past(out_free && v_s3 && send_s3))
		else $error("reply ident moved without an echo reply");

	a_pipe_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !out_free |=> v_s3 && $stable(kind_s3))
		else $error("classified verdict lost while output stalled");

endmodule

`default_nettype wire
